@@ rtl/core/e2d_pkg.sv @@
// package for the extended-to-double converter: constants and field types
package e2d_pkg;
  localparam int unsigned ExtExpW = 15;
  localparam int unsigned MantW = 64;
  localparam int unsigned DblW = 64;
  localparam int unsigned LzW = 6;
  localparam logic [ExtExpW-1:0] ExpAllOnes = 15'h7FFF;
  localparam int ExtBias = 16383;
  localparam int DblBias = 1023;
  localparam int DblExpMax = 2047;
  localparam logic [DblW-1:0] DblInfBits = 64'h7FF0_0000_0000_0000;

  typedef logic [DblW-1:0] dbl_t;
endpackage

@@ rtl/core/e2d_norm.sv @@
// normalizer: leading-zero count and left shift of the significand
module e2d_norm (
  input  logic [e2d_pkg::MantW-1:0] mant_i,
  output logic [e2d_pkg::MantW-1:0] norm_o,
  output logic [e2d_pkg::LzW-1:0]   lz_o
);
  logic [e2d_pkg::MantW-1:0] s0, s1, s2, s3, s4, s5;
  logic [e2d_pkg::LzW-1:0] lz;

  // binary-search shift, six levels
  always_comb begin
    lz[5] = (mant_i[63:32] == 32'd0);
    s0 = lz[5] ? {mant_i[31:0], 32'd0} : mant_i;
    lz[4] = (s0[63:48] == 16'd0);
    s1 = lz[4] ? {s0[47:0], 16'd0} : s0;
    lz[3] = (s1[63:56] == 8'd0);
    s2 = lz[3] ? {s1[55:0], 8'd0} : s1;
    lz[2] = (s2[63:60] == 4'd0);
    s3 = lz[2] ? {s2[59:0], 4'd0} : s2;
    lz[1] = (s3[63:62] == 2'd0);
    s4 = lz[1] ? {s3[61:0], 2'd0} : s3;
    lz[0] = ~s4[63];
    s5 = lz[0] ? {s4[62:0], 1'b0} : s4;
  end

  assign norm_o = s5;
  assign lz_o = lz;
endmodule

@@ rtl/core/extended80_to_double.sv @@
// Converts one 80-bit extended float to binary64 per cycle while out_ready_i is high.
// Input register, one stage of normalize/round logic, result register. A transaction
// accepted into the input register passes to the result register when that moves, and
// leaves it when out_ready_i is high. One transaction per cycle is sustained while
// out_ready_i is high. The result register moves whenever it is empty or its result is
// being taken, and the input register moves whenever it is empty or the result register
// moves. So in_ready_o is high whenever out_ready_i is high or either stage is empty.
module extended80_to_double (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sign_exponent_i,
  input  logic [63:0] mantissa_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] double_bits_o
);
  logic        iv_q, ov_q;
  logic [15:0] se_q;
  logic [63:0] m_q;
  e2d_pkg::dbl_t res_q, res_d;
  logic adv_o, adv_i;

  assign adv_o = ~ov_q | out_ready_i;
  assign adv_i = ~iv_q | adv_o;
  assign in_ready_o = adv_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= 1'b0;
    else if (adv_i) iv_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      se_q <= sign_exponent_i;
      m_q <= mantissa_i;
    end
  end

  logic [63:0] n;
  logic [5:0]  lz;
  e2d_norm u_norm (.mant_i(m_q), .norm_o(n), .lz_o(lz));

  // rounding: be = e - 16383 + 1023 - lz
  logic signed [17:0] be;
  logic [6:0]  sh;
  logic [63:0] q;
  logic [127:0] wide;
  logic half, sticky, subn;
  logic [63:0] mag;
  always_comb begin
    be = $signed({3'd0, se_q[14:0]}) - 18'sd15360 - $signed({12'd0, lz});
    subn = (be < 18'sd1);
    sh = subn ? 7'(18'sd12 - be) : 7'd11;
    wide = {n, 64'd0} >> sh;
    q = wide[127:64];
    half = wide[63];
    sticky = (wide[62:0] != 63'd0);
    if (half && (sticky || q[0])) q = q + 64'd1;
    mag = q;
    if (se_q[14:0] == e2d_pkg::ExpAllOnes) mag = e2d_pkg::DblInfBits;
    else if (m_q == 64'd0) mag = 64'd0;
    else if (be >= 18'sd2047) mag = e2d_pkg::DblInfBits;
    else if (!subn) mag = {1'b0, 11'(be - 18'sd1), 52'd0} + q;
    else if (be < -18'sd52) mag = 64'd0;
    res_d = {se_q[15], 63'd0} | mag;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv_o) ov_q <= iv_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_o && iv_q) res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign double_bits_o = res_q;
endmodule

@@ rtl/core/e2d_checker.sv @@
// port checker for the converter, bound to the top level
module e2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] sign_exponent_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] double_bits_o
);
  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(double_bits_o))
    else $error("result changed while stalled");
  // ready when output side free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o) else $error("ready dropped with free output");
  // all-ones exponent gives infinity under free flow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && sign_exponent_i[14:0] == e2d_pkg::ExpAllOnes && out_ready_i
    ##1 out_ready_i |=> out_valid_o && double_bits_o[62:0] == e2d_pkg::DblInfBits[62:0])
    else $error("infinity missing");
  // a fresh result needs a transaction accepted through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("invented result");
endmodule

bind extended80_to_double e2d_checker u_e2d_checker (.*);

@@ tb/sv/extended80_to_double_tb.sv @@
// testbench for the extended-to-double converter: directed table, random items, scoreboard
module extended80_to_double_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int NumRandom = 500;

  // directed stimulus row; chk set when the result is typed in
  typedef struct {
    logic [15:0]   se;
    logic [63:0]   man;
    bit            chk;
    e2d_pkg::dbl_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] sign_exponent_i = '0;
  logic [63:0] mantissa_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] double_bits_o;

  e2d_pkg::dbl_t expected_doubles[$];
  dir_row_t      dir_rows[$];
  int            errors = 0;
  int            idle_cycles = 0;
  int            in_idle_pct = 0;
  int            out_idle_pct = 0;
  bit            hold_off = 1'b0;
  bit            stim_done = 1'b0;

  extended80_to_double dut (.*);

  always #5 clk_i = ~clk_i;

  // round n / 2^sh to nearest even, sh in 1..64
  function automatic logic [63:0] rne_shift(logic [63:0] n, int sh);
    logic [63:0] q;
    logic        half;
    logic [63:0] sticky;
    q = (sh < 64) ? (n >> sh) : 64'd0;
    half = n[sh-1];
    sticky = (sh == 1) ? 64'd0 : (n & ((64'd1 << (sh - 1)) - 64'd1));
    if (half && (sticky != 0 || q[0])) q = q + 64'd1;
    return q;
  endfunction

  // predicted binary64 encoding of one extended value
  function automatic e2d_pkg::dbl_t convert_ext(logic [15:0] se, logic [63:0] man);
    logic [14:0] e;
    logic [63:0] n;
    logic [63:0] mag;
    int          p;
    int          be;
    e = se[14:0];
    if (e == e2d_pkg::ExpAllOnes) mag = e2d_pkg::DblInfBits;
    else if (man == 0) mag = '0;
    else begin
      p = 63;
      while (!man[p]) p--;
      n = man << (63 - p);
      be = int'(e) - e2d_pkg::ExtBias - 63 + p + e2d_pkg::DblBias;
      if (be >= e2d_pkg::DblExpMax) mag = e2d_pkg::DblInfBits;
      else if (be >= 1) mag = (64'(be - 1) << 52) + rne_shift(n, 11);
      else if (12 - be > 64) mag = '0;
      else mag = rne_shift(n, 12 - be);
    end
    return {se[15], 63'd0} | mag;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random item, mostly in or near the double range
  task automatic rand_item(output logic [15:0] se, output logic [63:0] man);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    se[15] = 1'($urandom_range(0, 1));
    if (sel < 55) se[14:0] = 15'($urandom_range(16383 - 1100, 16383 + 1100));
    else if (sel < 65) se[14:0] = 15'($urandom_range(16383 - 1090, 16383 - 1010));
    else if (sel < 70) se[14:0] = e2d_pkg::ExpAllOnes;
    else if (sel < 73) se[14:0] = '0;
    else se[14:0] = 15'($urandom());
    man = rand64();
    case ($urandom_range(0, 5))
      0: man = man >> $urandom_range(1, 63);
      1: man = {1'b1, 52'($urandom_range(0, 3) * 64'h5555_5555_5555), 11'h400};
      2: man = {1'b1, man[62:11], 11'h400};
      default: man[63] = 1'b1;
    endcase
    if ($urandom_range(0, 40) == 0) man = '0;
  endtask

  // send one transaction, holding valid until accepted
  task automatic send_item(logic [15:0] se, logic [63:0] man);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sign_exponent_i <= se;
    mantissa_i <= man;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_phase(int k);
    case (k % 4)
      0: begin in_idle_pct = 0; out_idle_pct = 0; end
      1: begin in_idle_pct = 68; out_idle_pct = 0; end
      2: begin in_idle_pct = 0; out_idle_pct = 68; end
      default: begin in_idle_pct = 19; out_idle_pct = 19; end
    endcase
  endtask

  // stimulus
  initial begin
    logic [15:0]   se;
    logic [63:0]   man;
    e2d_pkg::dbl_t want;
    dir_rows = '{
      '{16'h0000, 64'h0, 1'b1, 64'h0},
      '{16'h8000, 64'h0, 1'b1, 64'h8000_0000_0000_0000},
      '{16'h7FFF, 64'h0, 1'b1, 64'h7FF0_0000_0000_0000},
      '{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFF0_0000_0000_0000},
      '{16'h7FFF, 64'hC000_0000_0000_0000, 1'b1, 64'h7FF0_0000_0000_0000},
      '{16'h3FFF, 64'h8000_0000_0000_0000, 1'b1, 64'h3FF0_0000_0000_0000},
      '{16'hBFFF, 64'h8000_0000_0000_0000, 1'b1, 64'hBFF0_0000_0000_0000},
      '{16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
      '{16'h8001, 64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000},
      '{16'h7FFE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h7FF0_0000_0000_0000},
      '{16'h3FFF, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
      '{16'h3FFF, 64'h4000_0000_0000_0000, 1'b0, 64'h0},
      '{16'h43FE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{16'h43FE, 64'hFFFF_FFFF_FFFF_F800, 1'b0, 64'h0},
      '{16'h43FE, 64'hFFFF_FFFF_FFFF_F7FF, 1'b0, 64'h0},
      '{16'h3FFF, 64'h8000_0000_0000_0400, 1'b0, 64'h0},
      '{16'h3FFF, 64'h8000_0000_0000_0C00, 1'b0, 64'h0},
      '{16'h3FFF, 64'h8000_0000_0000_0401, 1'b0, 64'h0},
      '{16'h3C01, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{16'h3C00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{16'h3BCD, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{16'h3BCC, 64'h8000_0000_0000_0001, 1'b0, 64'h0},
      '{16'h3BCC, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{16'h3BCB, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{16'h0001, 64'h0000_0000_0000_0001, 1'b0, 64'h0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed table
    foreach (dir_rows[i]) begin
      want = convert_ext(dir_rows[i].se, dir_rows[i].man);
      if (dir_rows[i].chk && want !== dir_rows[i].res) begin
        $display("%0t table row %0d: expected %h predicted %h", $realtime, i,
                 dir_rows[i].res, want);
        errors++;
      end
      expected_doubles.push_back(dir_rows[i].chk ? dir_rows[i].res : want);
      send_item(dir_rows[i].se, dir_rows[i].man);
    end
    // random items across idling phases, with one long receiver hold-off
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 60 == 0) set_phase(i / 60);
      if (i == 250) hold_off = 1'b1;
      rand_item(se, man);
      expected_doubles.push_back(convert_ext(se, man));
      send_item(se, man);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver ready, with random stalls and the long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off && hold_cnt < 40) begin
        hold_cnt++;
        out_ready_i <= 1'b0;
      end else begin
        if (hold_off) hold_off = 1'b0;
        out_ready_i <= rst_ni && ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_doubles.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $realtime, double_bits_o);
        errors++;
      end else begin
        if (double_bits_o !== expected_doubles[0]) begin
          $display("%0t double_bits mismatch: expected %h actual %h", $realtime,
                   expected_doubles[0], double_bits_o);
          errors++;
        end
        void'(expected_doubles.pop_front());
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_doubles.size() == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_doubles.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/e2d_pkg.sv
rtl/core/e2d_norm.sv
rtl/core/extended80_to_double.sv
rtl/core/e2d_checker.sv
tb/sv/extended80_to_double_tb.sv
